// ----- sv/csa_pkg.sv -----
package csa_pkg;

  // Table size and derived index width.
  localparam int SLOT_COUNT = 10;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Field widths.
  localparam int ID_W       = 32;
  localparam int TIME_W     = 32;
  localparam int SWEEP_W    = 4;
  localparam int LIMIT_W    = 8;
  localparam int CNT_W      = 4;
  localparam int SLOT_OUT_W = 4;
  localparam int OUTCOME_W  = 3;
  localparam int MASK_W     = 10;

  // Register port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register reset values.
  localparam logic [SWEEP_W-1:0] SWEEP_INTERVAL_RST = SWEEP_W'(10);
  localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RST     = LIMIT_W'(2);

  // Register indexes, decoded from the word address bit.
  localparam logic REG_SWEEP_INTERVAL = 1'b0;
  localparam logic REG_IDLE_LIMIT     = 1'b1;

  typedef enum logic [OUTCOME_W-1:0] {
    OC_DEFAULT  = 3'd0,
    OC_MATCH    = 3'd1,
    OC_FREE     = 3'd2,
    OC_ELDEST   = 3'd3,
    OC_FALLBACK = 3'd4
  } outcome_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_MATCH,
    S_FREE,
    S_ELDEST,
    S_DECIDE,
    S_OUT
  } state_t;

endpackage

// ----- sv/csa_req_if.sv -----
interface csa_req_if;
  import csa_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [ID_W-1:0] channel_id;
  logic [TIME_W-1:0]      now_seconds;

  modport source (output valid, channel_id, now_seconds, input ready);
  modport sink (input valid, channel_id, now_seconds, output ready);

endinterface

// ----- sv/csa_res_if.sv -----
interface csa_res_if;
  import csa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [SLOT_OUT_W-1:0] slot;
  logic [OUTCOME_W-1:0]  outcome;
  logic [MASK_W-1:0]     expired_mask;

  modport source (output valid, slot, outcome, expired_mask, input ready);
  modport sink (input valid, slot, outcome, expired_mask, output ready);

endinterface

// ----- sv/channel_slot_assign_with_idle_expiry.sv -----
// Sequence: a negative id goes straight to the result load; any other id runs an optional sweep,
// then match, free and eldest passes of one slot per cycle through one subtract and compare unit,
// a decide state and a result load; the match and free passes end at their first hit.
// Throughput: one request at a time; the next is accepted once the result is in the output
// register, which may still be waiting to be taken.
// Reset (synchronous, active high): all slots free with time 0, counter 0, registers default.
module channel_slot_assign_with_idle_expiry (
  input  logic                               clk,
  input  logic                               rst,
  csa_req_if.sink                            req,
  csa_res_if.source                          res,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [csa_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [csa_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [csa_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import csa_pkg::*;

  // Configuration registers.
  logic [SWEEP_W-1:0] sweep_interval;
  logic [LIMIT_W-1:0] idle_limit;

  // Slot table and request counter.
  logic [ID_W-1:0]    slot_owner     [SLOT_COUNT];
  logic [TIME_W-1:0]  slot_last_used [SLOT_COUNT];
  logic [CNT_W-1:0]   request_counter;

  // Sequencer and working registers.
  state_t                    state, state_next;
  logic [SLOT_W-1:0]         idx;
  logic [ID_W-1:0]           cur_id;
  logic [TIME_W-1:0]         cur_now;
  logic [SLOT_COUNT-1:0]     mask;
  logic signed [TIME_W-1:0]  largest;
  logic [SLOT_W-1:0]         eldest;
  logic                      eldest_found;
  logic [SLOT_W-1:0]         pend_slot;
  outcome_t                  pend_outcome;

  // Output register.
  logic                      res_valid;
  logic [SLOT_OUT_W-1:0]     res_slot;
  outcome_t                  res_outcome;
  logic [MASK_W-1:0]         res_mask;

  // Sequencer controls.
  logic                      tbl_we;
  logic [SLOT_W-1:0]         tbl_idx;
  logic [ID_W-1:0]           tbl_owner;
  logic [TIME_W-1:0]         tbl_time;
  logic                      pend_load;
  logic [SLOT_W-1:0]         pend_slot_next;
  outcome_t                  pend_outcome_next;
  logic                      mask_set;
  logic                      idx_step;
  logic                      res_load;
  logic                      track_eldest;

  // Shared unit signals.
  logic                      req_fire;
  logic                      cfg_write;
  logic [CNT_W-1:0]          counter_inc;
  logic                      sweep_due;
  logic                      idx_last;
  logic [ID_W-1:0]           entry_owner;
  logic [TIME_W-1:0]         entry_last;
  logic signed [TIME_W-1:0]  idle;
  logic signed [TIME_W-1:0]  limit_s;
  logic                      idle_over_limit;
  logic                      idle_beats_largest;
  logic                      eldest_over_limit;

  // Handshake and counter.
  assign req.ready   = (state == S_IDLE);
  assign req_fire    = req.valid && req.ready;
  assign counter_inc = request_counter + CNT_W'(1);
  assign sweep_due   = (counter_inc >= sweep_interval);
  assign idx_last    = (idx == SLOT_W'(SLOT_COUNT - 1));

  // Shared subtract and compare unit, fed by the slot under the scan index.
  assign entry_owner        = slot_owner[idx];
  assign entry_last         = slot_last_used[idx];
  assign idle               = $signed(cur_now - entry_last);
  assign limit_s            = $signed({{(TIME_W - LIMIT_W){1'b0}}, idle_limit});
  assign idle_over_limit    = (idle > limit_s);
  assign idle_beats_largest = (idle > largest);
  assign eldest_over_limit  = eldest_found && (largest > limit_s);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          if (req.channel_id[ID_W-1]) state_next = S_OUT;
          else if (sweep_due)         state_next = S_SWEEP;
          else                        state_next = S_MATCH;
        end
      end
      S_SWEEP: begin
        if (idx_last) state_next = S_MATCH;
      end
      S_MATCH: begin
        if (entry_owner == cur_id) state_next = S_OUT;
        else if (idx_last)         state_next = S_FREE;
      end
      S_FREE: begin
        if (entry_owner == '0) state_next = S_OUT;
        else if (idx_last)     state_next = S_ELDEST;
      end
      S_ELDEST: begin
        if (idx_last) state_next = S_DECIDE;
      end
      S_DECIDE: state_next = S_OUT;
      S_OUT: begin
        if (!res_valid || res.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    tbl_we            = 1'b0;
    tbl_idx           = idx;
    tbl_owner         = cur_id;
    tbl_time          = cur_now;
    pend_load         = 1'b0;
    pend_slot_next    = idx;
    pend_outcome_next = OC_MATCH;
    mask_set          = 1'b0;
    idx_step          = 1'b0;
    res_load          = 1'b0;
    track_eldest      = 1'b0;
    unique case (state)
      S_SWEEP: begin
        idx_step = 1'b1;
        if (entry_owner != '0 && idle_over_limit) begin
          tbl_we    = 1'b1;
          tbl_owner = '0;
          tbl_time  = '0;
          mask_set  = 1'b1;
        end
      end
      S_MATCH: begin
        idx_step = 1'b1;
        if (entry_owner == cur_id) begin
          tbl_we            = 1'b1;
          tbl_owner         = entry_owner;
          pend_load         = 1'b1;
          pend_outcome_next = OC_MATCH;
        end
      end
      S_FREE: begin
        idx_step = 1'b1;
        if (entry_owner == '0) begin
          tbl_we            = 1'b1;
          pend_load         = 1'b1;
          pend_outcome_next = OC_FREE;
        end
      end
      S_ELDEST: begin
        idx_step     = 1'b1;
        track_eldest = idle_beats_largest;
      end
      S_DECIDE: begin
        pend_load = 1'b1;
        if (eldest_over_limit) begin
          tbl_we            = 1'b1;
          tbl_idx           = eldest;
          pend_slot_next    = eldest;
          pend_outcome_next = OC_ELDEST;
        end else begin
          pend_slot_next    = '0;
          pend_outcome_next = OC_FALLBACK;
        end
      end
      S_OUT: res_load = !res_valid || res.ready;
      default: begin
      end
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Scan index, working registers and request counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx             <= '0;
      request_counter <= '0;
    end else if (req_fire) begin
      idx          <= '0;
      cur_id       <= req.channel_id;
      cur_now      <= req.now_seconds;
      mask         <= '0;
      largest      <= '1;
      eldest       <= '0;
      eldest_found <= 1'b0;
      pend_slot    <= '0;
      pend_outcome <= OC_DEFAULT;
      if (!req.channel_id[ID_W-1]) begin
        request_counter <= sweep_due ? '0 : counter_inc;
      end
    end else begin
      if (idx_step) idx <= idx_last ? '0 : idx + SLOT_W'(1);
      if (mask_set) mask[idx] <= 1'b1;
      if (track_eldest) begin
        largest      <= idle;
        eldest       <= idx;
        eldest_found <= 1'b1;
      end
      if (pend_load) begin
        pend_slot    <= pend_slot_next;
        pend_outcome <= pend_outcome_next;
      end
    end
  end

  // Slot table: one write port at the sequencer's address.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < SLOT_COUNT; t++) begin
        slot_owner[t]     <= '0;
        slot_last_used[t] <= '0;
      end
    end else if (tbl_we) begin
      slot_owner[tbl_idx]     <= tbl_owner;
      slot_last_used[tbl_idx] <= tbl_time;
    end
  end

  // Output register decouples the result from the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_slot    <= SLOT_OUT_W'(pend_slot);
      res_outcome <= pend_outcome;
      res_mask    <= MASK_W'(mask);
    end
  end

  assign res.valid        = res_valid;
  assign res.slot         = res_slot;
  assign res.outcome      = res_outcome;
  assign res.expired_mask = res_mask;

  // Register port: word address bit selects the register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_interval <= SWEEP_INTERVAL_RST;
      idle_limit     <= IDLE_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (paddr[APB_ADDR_W-1])
        REG_SWEEP_INTERVAL: sweep_interval <= pwdata[SWEEP_W-1:0];
        REG_IDLE_LIMIT:     idle_limit     <= pwdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[APB_ADDR_W-1])
      REG_SWEEP_INTERVAL: prdata = {{(APB_DATA_W - SWEEP_W){1'b0}}, sweep_interval};
      REG_IDLE_LIMIT:     prdata = {{(APB_DATA_W - LIMIT_W){1'b0}}, idle_limit};
      default:            prdata = '0;
    endcase
  end

  // A negative id goes straight to the result stage with the default answer.
  assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.channel_id[ID_W-1]) |=>
      (state == S_OUT && pend_outcome == OC_DEFAULT && pend_slot == '0 && mask == '0))
    else $error("negative id did not take the default path");

  // The fallback answer always names slot zero.
  assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.outcome == OC_FALLBACK) |-> (res.slot == '0))
    else $error("fallback result with nonzero slot");

  // Without a tracked eldest slot the running maximum keeps its start value.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && !eldest_found) |-> (largest == '1))
    else $error("eldest tracking changed without a candidate");

  // Scan index stays inside the table.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP || state == S_MATCH || state == S_FREE || state == S_ELDEST) |->
      (idx <= SLOT_W'(SLOT_COUNT - 1)))
    else $error("scan index out of range");

endmodule

// ----- tb/channel_slot_assign_with_idle_expiry_test.sv -----
`timescale 1ns / 1ps

module channel_slot_assign_with_idle_expiry_test;
  import csa_pkg::*;

  localparam logic [APB_ADDR_W-1:0] ADDR_SWEEP_INTERVAL = 3'd0;
  localparam logic [APB_ADDR_W-1:0] ADDR_IDLE_LIMIT     = 3'd4;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 4 * SLOT_COUNT + 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int NOISE_PCT     = 13;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 230;
  localparam int PROBE_ROWS    = 24;

  typedef struct {
    logic [SLOT_OUT_W-1:0] slot;
    outcome_t              outcome;
    logic [MASK_W-1:0]     expired;
  } slot_grant_t;

  typedef struct {
    logic signed [ID_W-1:0] id;
    logic [TIME_W-1:0]      now;
    bit                     known;
    logic [SLOT_OUT_W-1:0]  slot;
    outcome_t               outcome;
    logic [MASK_W-1:0]      expired;
  } probe_row_t;

  // Opening requests: the fixed expectations are those that follow directly from reset.
  probe_row_t probe_table [PROBE_ROWS] = '{
    '{-32'sd1,         32'd5,          1'b1, 4'd0, OC_DEFAULT,  10'd0},
    '{32'sh80000000,   32'hFFFFFFFF,   1'b1, 4'd0, OC_DEFAULT,  10'd0},
    '{32'sd0,          32'd0,          1'b1, 4'd0, OC_MATCH,    10'd0},
    '{32'sh7FFFFFFF,   32'd100,        1'b1, 4'd0, OC_FREE,     10'd0},
    '{32'sd1,          32'd100,        1'b0, 4'd0, OC_DEFAULT,  10'd0},
    '{32'sd2,          32'd100,        1'b0, 4'd0, OC_DEFAULT,  10'd0},
    '{32'sd3,          32'd100,        1'b0, 4'd0, OC_DEFAULT,  10'd0},
    '{32'sd4,          32'd100,        1'b0, 4'd0, OC_DEFAULT,  10'd0},
    '{32'sd5,          32'd100,        1'b0, 4'd0, OC_DEFAULT,  10'd0},
    '{32'sd6,          32'd100,        1'b0, 4'd0, OC_DEFAULT,  10'd0},
    '{32'sd7,          32'd100,        1'b0, 4'd0, OC_DEFAULT,  10'd0},
    '{32'sd8,          32'd100,        1'b0, 4'd0, OC_DEFAULT,  10'd0},
    '{32'sd9,          32'd100,        1'b0, 4'd0, OC_DEFAULT,  10'd0},
    '{32'sd50,         32'd101,        1'b1, 4'd0, OC_FALLBACK, 10'd0},
    '{32'sd51,         32'd200,        1'b1, 4'd0, OC_ELDEST,   10'd0},
    '{32'sd52,         32'hFFFFFFFF,   1'b1, 4'd0, OC_FALLBACK, 10'd0},
    '{32'sd53,         32'h80000063,   1'b1, 4'd1, OC_ELDEST,   10'd0},
    '{32'sd5,          32'd300,        1'b1, 4'd5, OC_MATCH,    10'd0},
    '{32'sd0,          32'd301,        1'b0, 4'd0, OC_DEFAULT,  10'd0},
    '{32'sd77,         32'd302,        1'b0, 4'd0, OC_DEFAULT,  10'd0},
    '{32'sd78,         32'd5000,       1'b0, 4'd0, OC_DEFAULT,  10'd0},
    '{32'sd79,         32'd5000,       1'b0, 4'd0, OC_DEFAULT,  10'd0},
    '{32'sh7FFFFFFF,   32'd5001,       1'b0, 4'd0, OC_DEFAULT,  10'd0},
    '{-32'sd5,         32'd0,          1'b0, 4'd0, OC_DEFAULT,  10'd0}
  };

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  csa_req_if req_ch ();
  csa_res_if res_ch ();

  channel_slot_assign_with_idle_expiry dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the slot table, the request counter and the two registers.
  logic [ID_W-1:0]   tbl_owner     [SLOT_COUNT];
  logic [TIME_W-1:0] tbl_last_used [SLOT_COUNT];
  logic [CNT_W-1:0]  req_count;
  logic [SWEEP_W-1:0] cfg_sweep;
  logic [LIMIT_W-1:0] cfg_limit;

  slot_grant_t pending_grants [$];
  slot_grant_t oldest_grant;
  int errors;
  int cycle_count;
  int idle_pct;
  int hold_left;
  bit hold_request;
  logic [TIME_W-1:0] clock_secs;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("channel_slot_assign_with_idle_expiry regression: fail");
      $finish;
    end
  end

  // Idle time is the wrapped difference read as a signed 32-bit number.
  function automatic int idle_secs(logic [TIME_W-1:0] now, logic [TIME_W-1:0] last);
    logic [TIME_W-1:0] diff;
    diff = now - last;
    return $signed(diff);
  endfunction

  // Works out the slot grant for one request and updates the shadow table.
  function automatic slot_grant_t pick_slot(logic [ID_W-1:0] id, logic [TIME_W-1:0] now);
    slot_grant_t g;
    int d;
    int largest;
    int eldest;
    bit done;
    g.slot = '0;
    g.outcome = OC_FALLBACK;
    g.expired = '0;
    done = 1'b0;
    if (id[ID_W-1]) begin
      g.outcome = OC_DEFAULT;
      return g;
    end

    // Periodic expiry sweep.
    req_count = req_count + 1'b1;
    if (req_count >= cfg_sweep) begin
      req_count = '0;
      for (int t = 0; t < SLOT_COUNT; t++) begin
        if (tbl_owner[t] != 0 && idle_secs(now, tbl_last_used[t]) > int'(cfg_limit)) begin
          tbl_owner[t] = '0;
          tbl_last_used[t] = '0;
          g.expired[t] = 1'b1;
        end
      end
    end

    // Exact owner match; id zero matches a free slot and leaves it free.
    for (int t = 0; t < SLOT_COUNT && !done; t++) begin
      if (tbl_owner[t] == id) begin
        tbl_last_used[t] = now;
        g.slot = SLOT_OUT_W'(t);
        g.outcome = OC_MATCH;
        done = 1'b1;
      end
    end

    // First free slot.
    for (int t = 0; t < SLOT_COUNT && !done; t++) begin
      if (tbl_owner[t] == 0) begin
        tbl_last_used[t] = now;
        tbl_owner[t] = id;
        g.slot = SLOT_OUT_W'(t);
        g.outcome = OC_FREE;
        done = 1'b1;
      end
    end

    // Eldest slot, first among ties; negative idle times never qualify.
    if (!done) begin
      eldest = -1;
      largest = -1;
      for (int t = 0; t < SLOT_COUNT; t++) begin
        d = idle_secs(now, tbl_last_used[t]);
        if (d > largest) begin
          largest = d;
          eldest = t;
        end
      end
      if (eldest >= 0 && largest > int'(cfg_limit)) begin
        tbl_last_used[eldest] = now;
        tbl_owner[eldest] = id;
        g.slot = SLOT_OUT_W'(eldest);
        g.outcome = OC_ELDEST;
      end
    end
    return g;
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    errors++;
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      res_ch.ready = 1'b0;
      hold_left--;
    end else begin
      res_ch.ready = ($urandom_range(99) >= idle_pct);
    end
  end

  // Each accepted result word is compared with the oldest expected grant.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result word, slot %0d outcome %0d mask %0h", $time,
                 res_ch.slot, res_ch.outcome, res_ch.expired_mask);
        errors++;
      end else begin
        oldest_grant = pending_grants.pop_front();
        if (res_ch.slot !== oldest_grant.slot)
          report("slot", 32'(oldest_grant.slot), 32'(res_ch.slot));
        if (res_ch.outcome !== oldest_grant.outcome)
          report("outcome", 32'(oldest_grant.outcome), 32'(res_ch.outcome));
        if (res_ch.expired_mask !== oldest_grant.expired)
          report("expired_mask", 32'(oldest_grant.expired), 32'(res_ch.expired_mask));
      end
    end
  end

  // Offers one request word, with random gaps, and waits until it is taken.
  task automatic offer_request(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] now);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.channel_id = id;
    req_ch.now_seconds = now;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Drops valid and waits until every expected result word has come back.
  task automatic settle();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data,
                            output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic check_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] want);
    logic [APB_DATA_W-1:0] got;
    apb_access(1'b0, addr, '0, got);
    if (got !== want)
      report("register readback", want, got);
  endtask

  // Writes both registers while the block is idle and reads them back.
  task automatic set_policy(input logic [SWEEP_W-1:0] sweep, input logic [LIMIT_W-1:0] limit);
    logic [APB_DATA_W-1:0] unused;
    apb_access(1'b1, ADDR_SWEEP_INTERVAL, APB_DATA_W'(sweep), unused);
    apb_access(1'b1, ADDR_IDLE_LIMIT, APB_DATA_W'(limit), unused);
    cfg_sweep = sweep;
    cfg_limit = limit;
    check_reg(ADDR_SWEEP_INTERVAL, APB_DATA_W'(sweep));
    check_reg(ADDR_IDLE_LIMIT, APB_DATA_W'(limit));
  endtask

  // Mostly a small pool of ids so that matches and replacements are common.
  function automatic logic [ID_W-1:0] draw_channel();
    int r;
    r = $urandom_range(99);
    if (r < 8) return {1'b1, 31'($urandom)};
    if (r < 12) return $urandom;
    if (r < 16) return '0;
    if (r < 20) return {1'b0, 31'($urandom)};
    return ID_W'($urandom_range(1, 14));
  endfunction

  // Time mostly creeps forward, sometimes jumps, now and then goes back.
  function automatic logic [TIME_W-1:0] draw_time();
    int r;
    r = $urandom_range(99);
    if (r < 70) clock_secs = clock_secs + $urandom_range(0, 3);
    else if (r < 90) clock_secs = clock_secs + $urandom_range(0, 600);
    else if (r < 95) clock_secs = $urandom;
    else clock_secs = clock_secs - $urandom_range(1, 5);
    return clock_secs;
  endfunction

  initial begin
    slot_grant_t grant;
    logic [SWEEP_W-1:0] sweep;
    logic [LIMIT_W-1:0] limit;
    logic [ID_W-1:0] id;
    logic [TIME_W-1:0] now;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.channel_id = '0;
    req_ch.now_seconds = '0;
    res_ch.ready = 1'b0;
    errors = 0;
    cycle_count = 0;
    idle_pct = NOISE_PCT;
    hold_left = 0;
    hold_request = 1'b0;
    clock_secs = 32'd6000;
    for (int t = 0; t < SLOT_COUNT; t++) begin
      tbl_owner[t] = '0;
      tbl_last_used[t] = '0;
    end
    req_count = '0;
    cfg_sweep = SWEEP_INTERVAL_RST;
    cfg_limit = IDLE_LIMIT_RST;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    check_reg(ADDR_SWEEP_INTERVAL, APB_DATA_W'(SWEEP_INTERVAL_RST));
    check_reg(ADDR_IDLE_LIMIT, APB_DATA_W'(IDLE_LIMIT_RST));

    // Directed requests under the reset settings.
    for (int i = 0; i < PROBE_ROWS; i++) begin
      offer_request(probe_table[i].id, probe_table[i].now);
      grant = pick_slot(probe_table[i].id, probe_table[i].now);
      if (probe_table[i].known) begin
        grant.slot = probe_table[i].slot;
        grant.outcome = probe_table[i].outcome;
        grant.expired = probe_table[i].expired;
      end
      pending_grants.push_back(grant);
    end
    settle();

    // Random phases, each under its own register settings.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin sweep = 4'd1;  limit = 8'd0;   end
        1: begin sweep = 4'd15; limit = 8'd255; end
        2: begin sweep = 4'd4;  limit = 8'd2;   end
        3: begin sweep = 4'd1;  limit = 8'd255; end
        4: begin sweep = 4'd15; limit = 8'd0;   end
        5: begin sweep = 4'd7;  limit = 8'd30;  end
        default: begin
          sweep = SWEEP_W'($urandom_range(1, 15));
          limit = LIMIT_W'($urandom_range(0, 255));
        end
      endcase
      set_policy(sweep, limit);
      idle_pct = (p == 1) ? 0 : NOISE_PCT;
      if (p == 2) hold_request = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 4 && i == PHASE_ITEMS / 2) settle();
        id = draw_channel();
        now = draw_time();
        offer_request(id, now);
        pending_grants.push_back(pick_slot(id, now));
      end
      settle();
    end

    if (errors == 0 && pending_grants.size() == 0) begin
      $display("channel_slot_assign_with_idle_expiry regression: pass");
    end else begin
      $display("channel_slot_assign_with_idle_expiry regression: fail");
    end
    $finish;
  end

endmodule

// ----- channel_slot_assign_with_idle_expiry.f -----
sv/csa_pkg.sv
sv/csa_req_if.sv
sv/csa_res_if.sv
sv/channel_slot_assign_with_idle_expiry.sv
tb/channel_slot_assign_with_idle_expiry_test.sv
